@@ design/rmg_pkg.sv @@
package rmg_pkg;
  localparam int BufferDepth = 4096;
  localparam int AddrBits = 12;
  localparam int CountBits = 13;
  localparam int SampleBits = 16;
  localparam int EnergyBits = 44;
  localparam logic [15:0] UnityGain = 16'd4096;
  localparam logic [15:0] MaxGainReset = 16'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_DIV,
    G_SQRT,
    G_DONE
  } gain_state_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;
endpackage

@@ design/rmg_gain_unit.sv @@
module rmg_gain_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rmg_pkg::EnergyBits-1:0]      ref_energy,
  input  logic [rmg_pkg::EnergyBits-1:0]      proc_energy,
  input  logic [15:0]                         max_gain,
  output logic                                done,
  output logic [15:0]                         gain
);
  import rmg_pkg::*;

  // Restoring divide producing a 32-bit quotient (ratio < 256, 24 fraction bits),
  // then a bit-serial integer square root of that quotient.
  gain_state_t gst_r, gst_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [EnergyBits:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [67:0] dvd_r, dvd_nxt;
  logic [33:0] sx_r, sx_nxt;
  logic [33:0] sres_r, sres_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic [EnergyBits:0] rsh;
  logic [33:0] trial;
  logic [33:0] xs;

  assign done = (gst_r == G_DONE);
  assign gain = gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gst_r <= G_IDLE;
    end else begin
      gst_r <= gst_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    dvd_r  <= dvd_nxt;
    sx_r   <= sx_nxt;
    sres_r <= sres_nxt;
    gain_r <= gain_nxt;
  end

  always_comb begin
    gst_nxt  = gst_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvd_nxt  = dvd_r;
    sx_nxt   = sx_r;
    sres_nxt = sres_r;
    gain_nxt = gain_r;
    rsh      = {rem_r[EnergyBits-1:0], dvd_r[67]};
    xs       = {sx_r[31:0], q_r[31:30]};
    trial    = {sres_r[31:0], 2'b01};
    unique case (gst_r)
      G_IDLE: begin
        if (start) begin
          if (ref_energy == '0 || proc_energy == '0) begin
            gain_nxt = UnityGain;
            gst_nxt  = G_DONE;
          end else if ({8'd0, ref_energy[EnergyBits-1:8]} >= proc_energy) begin
            gain_nxt = max_gain;
            gst_nxt  = G_DONE;
          end else begin
            // dividend is ref_energy << 24; walk 68 bits one per cycle
            dvd_nxt = {ref_energy, 24'd0};
            rem_nxt = '0;
            q_nxt   = '0;
            cnt_nxt = 7'd0;
            gst_nxt = G_DIV;
          end
        end
      end
      G_DIV: begin
        if (rsh >= {1'b0, proc_energy}) begin
          rem_nxt = rsh - {1'b0, proc_energy};
          q_nxt   = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = rsh;
          q_nxt   = {q_r[30:0], 1'b0};
        end
        dvd_nxt = {dvd_r[66:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        // last quotient bit: hand the quotient to the square root
        if (cnt_r == 7'd67) begin
          gst_nxt  = G_SQRT;
          cnt_nxt  = 7'd0;
          sx_nxt   = '0;
          sres_nxt = '0;
        end
      end
      G_SQRT: begin
        if (xs >= trial) begin
          sx_nxt   = xs - trial;
          sres_nxt = {sres_r[32:0], 1'b1};
        end else begin
          sx_nxt   = xs;
          sres_nxt = {sres_r[32:0], 1'b0};
        end
        q_nxt   = {q_r[29:0], 2'b00};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd15) begin
          gain_nxt = (sres_nxt[15:0] > max_gain) ? max_gain : sres_nxt[15:0];
          gst_nxt  = G_DONE;
        end
      end
      G_DONE: begin
        gst_nxt = G_IDLE;
      end
      default: gst_nxt = G_IDLE;
    endcase
  end
endmodule

@@ design/rms_match_gain_limiter_top.sv @@
// RMS-matching gain limiter.
// Input channel (in_valid/in_ready) carries operation, ref_sample, proc_sample
// and final_pair. A load (operation 0) stores the processed sample in a
// 4096-entry sample RAM and adds both squares to saturating 44-bit energies;
// it produces no result. The pair marked final_pair closes the buffer.
// A drain (operation 1) returns one transaction on out_valid/out_ready:
// scaled_sample, end_of_buffer and nothing_ready. A drain result passes
// through RAM read, multiply and round/saturate before it is valid. The
// first drain of a buffer also runs the gain unit: a bit-serial divide
// and a square root, both skipped when an energy is zero or the ratio
// is 256 or more.
// The result sits in an output register; while the receiver stalls, the
// next load is still accepted, and a further drain waits.
// Reset (rst_n low, synchronous) empties the buffer, sets unity gain and
// max_gain to 4.0; no clearing pass is needed.
// cfg_max_gain is written when cfg_we is high; write only when idle.
module rms_match_gain_limiter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic signed [rmg_pkg::SampleBits-1:0] in_ref_sample,
  input  logic signed [rmg_pkg::SampleBits-1:0] in_proc_sample,
  input  logic                               in_final_pair,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rmg_pkg::SampleBits-1:0] out_scaled_sample,
  output logic                               out_end_of_buffer,
  output logic                               out_nothing_ready,
  input  logic                               cfg_we,
  input  logic [15:0]                        cfg_max_gain
);
  import rmg_pkg::*;

  state_t st_r, st_nxt;
  logic [15:0] max_gain_r;
  logic [EnergyBits-1:0] ref_e_r, ref_e_nxt, proc_e_r, proc_e_nxt;
  logic [CountBits-1:0] cnt_r, cnt_nxt, drn_r, drn_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic gain_rdy_r, gain_rdy_nxt, closed_r, closed_nxt;
  logic ov_r, ov_nxt;
  logic signed [SampleBits-1:0] os_r, os_nxt;
  logic oe_r, oe_nxt, on_r, on_nxt;
  logic last_r, last_nxt;
  logic signed [33:0] prod_r, prod_nxt;

  logic [SampleBits-1:0] mem [BufferDepth];
  logic [SampleBits-1:0] rd_r;
  logic we;
  logic [AddrBits-1:0] wr_addr;
  logic accept, clr;
  logic [31:0] rsq, psq;
  logic [EnergyBits-1:0] rb, pb;
  logic g_start, g_done;
  logic [15:0] g_gain;
  logic signed [33:0] rnd;

  assign accept = in_valid && in_ready;
  assign in_ready = (st_r == ST_IDLE) && (in_operation == OP_LOAD || !ov_r);
  assign out_valid = ov_r;
  assign out_scaled_sample = os_r;
  assign out_end_of_buffer = oe_r;
  assign out_nothing_ready = on_r;

  // Sample RAM: one write port for loads, one registered read for drains
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= in_proc_sample;
    rd_r <= mem[drn_r[AddrBits-1:0]];
  end

  rmg_gain_unit u_gain (
    .clk, .rst_n, .start(g_start), .ref_energy(ref_e_r), .proc_energy(proc_e_r),
    .max_gain(max_gain_r), .done(g_done), .gain(g_gain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; max_gain_r <= MaxGainReset;
      ref_e_r <= '0; proc_e_r <= '0; cnt_r <= '0; drn_r <= '0;
      gain_r <= UnityGain; gain_rdy_r <= 1'b0; closed_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) max_gain_r <= cfg_max_gain;
      ref_e_r <= ref_e_nxt; proc_e_r <= proc_e_nxt; cnt_r <= cnt_nxt;
      drn_r <= drn_nxt; gain_r <= gain_nxt; gain_rdy_r <= gain_rdy_nxt;
      closed_r <= closed_nxt; ov_r <= ov_nxt;
    end
    os_r <= os_nxt; oe_r <= oe_nxt; on_r <= on_nxt;
    last_r <= last_nxt; prod_r <= prod_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    ref_e_nxt = ref_e_r; proc_e_nxt = proc_e_r; cnt_nxt = cnt_r; drn_nxt = drn_r;
    gain_nxt = gain_r; gain_rdy_nxt = gain_rdy_r; closed_nxt = closed_r;
    ov_nxt = ov_r && !out_ready;
    os_nxt = os_r; oe_nxt = oe_r; on_nxt = on_r;
    last_nxt = last_r; prod_nxt = prod_r;
    we = 1'b0; g_start = 1'b0;
    clr = closed_r || (drn_r != '0);
    // a load into a discarded buffer starts again at entry zero
    wr_addr = clr ? '0 : cnt_r[AddrBits-1:0];
    rb = clr ? '0 : ref_e_r;
    pb = clr ? '0 : proc_e_r;
    rsq = 32'(signed'(in_ref_sample) * signed'(in_ref_sample));
    psq = 32'(signed'(in_proc_sample) * signed'(in_proc_sample));
    rnd = (prod_r + 34'sd2048) >>> 12;
    unique case (st_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_LOAD) begin
          if (clr) begin
            cnt_nxt = '0; drn_nxt = '0; gain_nxt = UnityGain;
            gain_rdy_nxt = 1'b0; closed_nxt = 1'b0;
          end
          if ((clr ? '0 : cnt_r) < CountBits'(BufferDepth)) begin
            we = 1'b1;
            ref_e_nxt = (rb > {EnergyBits{1'b1}} - EnergyBits'(rsq)) ?
                        {EnergyBits{1'b1}} : rb + EnergyBits'(rsq);
            proc_e_nxt = (pb > {EnergyBits{1'b1}} - EnergyBits'(psq)) ?
                         {EnergyBits{1'b1}} : pb + EnergyBits'(psq);
            cnt_nxt = (clr ? '0 : cnt_r) + 1'b1;
          end else begin
            ref_e_nxt = rb; proc_e_nxt = pb;
          end
          if (in_final_pair) closed_nxt = 1'b1;
        end else if (accept) begin
          if (!closed_r || drn_r >= cnt_r) begin
            os_nxt = '0; oe_nxt = 1'b0; on_nxt = 1'b1; ov_nxt = 1'b1;
          end else if (!gain_rdy_r) begin
            g_start = 1'b1; st_nxt = ST_DIV;
          end else begin
            st_nxt = ST_READ;
          end
        end
      end
      ST_DIV: begin
        if (g_done) begin
          gain_nxt = g_gain; gain_rdy_nxt = 1'b1; st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // RAM read of drn_r lands in rd_r
        last_nxt = (drn_r + 1'b1 == cnt_r);
        st_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt = 34'(signed'(rd_r) * signed'({1'b0, gain_r}));
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (rnd > 34'sd32767) os_nxt = 16'sh7fff;
        else if (rnd < -34'sd32768) os_nxt = -16'sh8000;
        else os_nxt = rnd[15:0];
        oe_nxt = last_r; on_nxt = 1'b0; ov_nxt = 1'b1;
        drn_nxt = drn_r + 1'b1;
        if (last_r) begin
          ref_e_nxt = '0; proc_e_nxt = '0; cnt_nxt = '0; drn_nxt = '0;
          gain_nxt = UnityGain; gain_rdy_nxt = 1'b0; closed_nxt = 1'b0;
        end
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule
